@@ sv/slot_table_search_and_placement_top_macros.svh @@
// Assertion macros shared by the slot table checker
`ifndef SLOT_TABLE_SEARCH_AND_PLACEMENT_TOP_MACROS_SVH
`define SLOT_TABLE_SEARCH_AND_PLACEMENT_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define STSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/stsp_pkg.sv @@
// Shared types and constants for the slot table search and placement block
package stsp_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int INDEX_W       = 6;

    typedef enum logic [2:0] {
        ACT_WRITE = 3'd0,
        ACT_COORD = 3'd1,
        ACT_ID    = 3'd2,
        ACT_KEY   = 3'd3,
        ACT_POINT = 3'd4,
        ACT_PLACE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } state_t;

    typedef logic signed [11:0] coord_t;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  size;
        logic        used;
        logic [31:0] object_id;
        logic [31:0] key;
    } entry_t;

    typedef struct packed {
        action_t     action;
        coord_t      qx;
        coord_t      qy;
        coord_t      x0;
        coord_t      x1;
        coord_t      y0;
        coord_t      y1;
        logic [31:0] word;
    } query_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] idx;
        logic               any_free;
        logic               blocked;
        logic               overlap;
    } token_t;

    typedef struct packed {
        logic               placement_ok;
        logic [INDEX_W-1:0] found_index;
        logic               found;
    } result_t;

endpackage

@@ sv/slot_table_search_and_placement_top.sv @@
// Slot table with searches and placement check, built as a row of slot cells
//
//  channel | dir | fields
//  --------+-----+-----------------------------------------------------------
//  s_*     | in  | request: tuser action, tdata slot/entry/query fields
//  m_*     | out | result: tdata found, found_index, placement_ok
//
//  A search or placement request sends a token along the cell row, one slot per
//  cycle; no new request is taken until its result is pushed. A write or an
//  unused action goes straight to the push. Reset clears every slot to free at
//  once. A stalled result waits in the output register; the next request is taken
//  meanwhile and its result waits in a pending register until the output drains.
module slot_table_search_and_placement_top #(
    parameter int SLOTS = stsp_pkg::SLOTS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [5:0] slot_index, [13:6] entry_x, [21:14] entry_y, [29:22] entry_size,
    // [30] entry_used, [62:31] entry_object_id, [94:63] entry_key,
    // [105:95] query_x, [116:106] query_y, [124:117] query_size,
    // [156:125] query_word, [159:157] zero
    input  logic [159:0] s_tdata,
    // [2:0] action
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] found, [6:1] found_index, [7] placement_ok
    output logic [7:0]   m_tdata
);

    stsp_pkg::state_t  state_reg;
    stsp_pkg::state_t  state_next;
    stsp_pkg::query_t  query_reg;
    stsp_pkg::query_t  query_next;
    logic              size_zero_reg;
    logic              inject_reg;
    stsp_pkg::result_t pend_reg;
    stsp_pkg::result_t pend_next;
    logic              out_valid_reg;
    stsp_pkg::result_t out_data_reg;

    logic              accept;
    logic              push_fire;
    logic              is_scan;
    stsp_pkg::action_t in_action;
    stsp_pkg::entry_t  in_entry;
    stsp_pkg::coord_t  qx12;
    stsp_pkg::coord_t  qy12;
    stsp_pkg::coord_t  half_s;
    stsp_pkg::coord_t  size_s;
    stsp_pkg::result_t scan_result;

    logic              tok_valid [0:SLOTS];
    stsp_pkg::token_t  tok       [0:SLOTS];

    assign in_action = stsp_pkg::action_t'(s_tuser);
    assign accept    = s_tvalid & s_tready;

    assign in_entry.x         = s_tdata[13:6];
    assign in_entry.y         = s_tdata[21:14];
    assign in_entry.size      = s_tdata[29:22];
    assign in_entry.used      = s_tdata[30];
    assign in_entry.object_id = s_tdata[62:31];
    assign in_entry.key       = s_tdata[94:63];

    assign qx12   = $signed({s_tdata[105], s_tdata[105:95]});
    assign qy12   = $signed({s_tdata[116], s_tdata[116:106]});
    assign half_s = $signed({5'b0, s_tdata[124:118]});
    assign size_s = $signed({4'b0, s_tdata[124:117]});

    always_comb
    begin
        query_next.action = in_action;
        query_next.qx     = qx12;
        query_next.qy     = qy12;
        query_next.x0     = qx12 - half_s;
        query_next.x1     = qx12 + size_s - half_s - 12'sd1;
        query_next.y0     = qy12 - half_s;
        query_next.y1     = qy12 + size_s - half_s - 12'sd1;
        query_next.word   = s_tdata[156:125];
    end

    always_comb
    begin
        unique case (in_action)
            stsp_pkg::ACT_COORD,
            stsp_pkg::ACT_ID,
            stsp_pkg::ACT_KEY,
            stsp_pkg::ACT_POINT,
            stsp_pkg::ACT_PLACE: is_scan = 1'b1;
            default:             is_scan = 1'b0;
        endcase
    end

    // cell row
    assign tok_valid[0] = inject_reg;
    assign tok[0]       = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic we;

        if (i < (1 << stsp_pkg::INDEX_W))
        begin : g_wr
            assign we = accept && (in_action == stsp_pkg::ACT_WRITE)
                     && (s_tdata[5:0] == stsp_pkg::INDEX_W'(i));
        end
        else
        begin : g_nowr
            assign we = 1'b0;
        end

        stsp_cell #(
            .CELL_ID (stsp_pkg::INDEX_W'(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .we        (we),
            .entry     (in_entry),
            .query     (query_reg),
            .in_valid  (tok_valid[i]),
            .in_tok    (tok[i]),
            .out_valid (tok_valid[i+1]),
            .out_tok   (tok[i+1])
        );
    end

    always_comb
    begin
        scan_result.found        = tok[SLOTS].found;
        scan_result.found_index  = tok[SLOTS].idx;
        scan_result.placement_ok = (query_reg.action == stsp_pkg::ACT_PLACE)
                                 && tok[SLOTS].any_free && !tok[SLOTS].blocked
                                 && (size_zero_reg || !tok[SLOTS].overlap);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = is_scan ? stsp_pkg::ST_SCAN : stsp_pkg::ST_PUSH;
                end
            end
            stsp_pkg::ST_SCAN:
            begin
                if (tok_valid[SLOTS])
                begin
                    state_next = stsp_pkg::ST_PUSH;
                end
            end
            stsp_pkg::ST_PUSH:
            begin
                if (push_fire)
                begin
                    state_next = stsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stsp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready  = 1'b0;
        push_fire = 1'b0;
        pend_next = pend_reg;
        unique case (state_reg)
            stsp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    pend_next = '0;
                end
            end
            stsp_pkg::ST_SCAN:
            begin
                if (tok_valid[SLOTS])
                begin
                    pend_next = scan_result;
                end
            end
            stsp_pkg::ST_PUSH:
            begin
                push_fire = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stsp_pkg::ST_IDLE;
            inject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            inject_reg <= accept && is_scan;
            if (push_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            query_reg     <= query_next;
            size_zero_reg <= (s_tdata[124:117] == 8'd0);
        end
        if (push_fire)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ sv/stsp_cell.sv @@
// One slot of the table: holds the slot and folds it into the passing search token
module stsp_cell #(
    parameter logic [stsp_pkg::INDEX_W-1:0] CELL_ID = '0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  stsp_pkg::entry_t entry,
    input  stsp_pkg::query_t query,
    input  logic             in_valid,
    input  stsp_pkg::token_t in_tok,
    output logic             out_valid,
    output stsp_pkg::token_t out_tok
);

    logic [7:0]       x_reg;
    logic [7:0]       y_reg;
    logic [7:0]       size_reg;
    logic             used_reg;
    logic [31:0]      id_reg;
    logic [31:0]      key_reg;
    logic             valid_reg;
    stsp_pkg::token_t tok_reg;
    stsp_pkg::token_t tok_next;

    stsp_pkg::coord_t sx;
    stsp_pkg::coord_t sy;
    stsp_pkg::coord_t h;
    stsp_pkg::coord_t lo_x;
    stsp_pkg::coord_t hi_x;
    stsp_pkg::coord_t lo_y;
    stsp_pkg::coord_t hi_y;
    logic             coord_eq;
    logic             covers;
    logic             overlaps;
    logic             match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            size_reg <= '0;
            used_reg <= 1'b0;
        end
        else if (we)
        begin
            x_reg    <= entry.x;
            y_reg    <= entry.y;
            size_reg <= entry.size;
            used_reg <= entry.used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            id_reg  <= entry.object_id;
            key_reg <= entry.key;
        end
    end

    assign sx   = $signed({4'b0, x_reg});
    assign sy   = $signed({4'b0, y_reg});
    assign h    = $signed({5'b0, size_reg[7:1]});
    assign lo_x = sx - h;
    assign hi_x = sx + h;
    assign lo_y = sy - h;
    assign hi_y = sy + h;

    assign coord_eq = (sx == query.qx) && (sy == query.qy);
    assign covers   = (query.qx >= lo_x) && (query.qx <= hi_x)
                   && (query.qy >= lo_y) && (query.qy <= hi_y);
    assign overlaps = (query.x0 <= hi_x) && (query.x1 >= lo_x)
                   && (query.y0 <= hi_y) && (query.y1 >= lo_y);

    always_comb
    begin
        unique case (query.action)
            stsp_pkg::ACT_COORD: match = coord_eq;
            stsp_pkg::ACT_ID:    match = (id_reg == query.word);
            stsp_pkg::ACT_KEY:   match = (key_reg == query.word);
            stsp_pkg::ACT_POINT: match = covers;
            default:             match = 1'b0;
        endcase
    end

    always_comb
    begin
        tok_next          = in_tok;
        tok_next.any_free = in_tok.any_free | ~used_reg;
        tok_next.blocked  = in_tok.blocked | (used_reg & coord_eq);
        tok_next.overlap  = in_tok.overlap | (used_reg & overlaps);
        if (!in_tok.found && used_reg && match)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = CELL_ID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

@@ sv/stsp_checker.sv @@
// Port-level checker for the slot table, bound to the top level
`include "slot_table_search_and_placement_top_macros.svh"

module stsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `STSP_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `STSP_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "second request taken during work")
    `STSP_ASSERT_NOW(a_kind_excl, m_tvalid, !(m_tdata[0] && m_tdata[7]), "found and placement_ok both set")
    `STSP_ASSERT_NOW(a_idx_zero, m_tvalid && !m_tdata[0], m_tdata[6:1] == 6'd0, "index set without a match")

endmodule

bind slot_table_search_and_placement_top stsp_checker u_stsp_checker (.*);

@@ bench/testbench.sv @@
// Testbench for the slot table search and placement block: stream driver, monitor, predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_SLOTS     = stsp_pkg::SLOTS_DEFAULT;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         ITEM_TARGET = 1750;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]         action;
        logic [5:0]         slot_index;
        logic [7:0]         entry_x;
        logic [7:0]         entry_y;
        logic [7:0]         entry_size;
        logic               entry_used;
        logic [31:0]        entry_object_id;
        logic [31:0]        entry_key;
        logic signed [10:0] query_x;
        logic signed [10:0] query_y;
        logic [7:0]         query_size;
        logic [31:0]        query_word;
    } request_t;

    typedef struct packed {
        logic       placement_ok;
        logic [5:0] found_index;
        logic       found;
    } answer_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [5:0] slot_index, [13:6] entry_x, [21:14] entry_y, [29:22] entry_size,
    // [30] entry_used, [62:31] entry_object_id, [94:63] entry_key,
    // [105:95] query_x, [116:106] query_y, [124:117] query_size,
    // [156:125] query_word, [159:157] zero
    logic [159:0] s_tdata = '0;
    // [2:0] action
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [0] found, [6:1] found_index, [7] placement_ok
    logic [7:0]   m_tdata;

    request_t request_q[$];
    answer_t  answer_q[$];
    request_t cur_req;
    answer_t  exp_answer;
    logic     req_taken = 1'b0;
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       n_items = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       ready_left = 0;

    // predictor copy of the table
    logic [7:0]  tbl_x[N_SLOTS];
    logic [7:0]  tbl_y[N_SLOTS];
    logic [7:0]  tbl_size[N_SLOTS];
    logic        tbl_used[N_SLOTS];
    logic [31:0] tbl_id[N_SLOTS];
    logic [31:0] tbl_key[N_SLOTS];

    // stimulus-side view of the table, updated as requests are queued
    logic [7:0]  plan_x[N_SLOTS];
    logic [7:0]  plan_y[N_SLOTS];
    logic [7:0]  plan_size[N_SLOTS];
    logic        plan_used[N_SLOTS];
    logic [31:0] plan_id[N_SLOTS];
    logic [31:0] plan_key[N_SLOTS];

    slot_table_search_and_placement_top #(
        .SLOTS(N_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic answer_t slot_table_answer(request_t r);
        answer_t a;
        int      qx;
        int      qy;
        int      qs;
        int      half;
        int      x0;
        int      x1;
        int      y0;
        int      y1;
        int      h;
        int      sx;
        int      sy;
        bit      hit;
        bit      any_free;
        bit      blocked;
        a = '0;
        qx = int'(r.query_x);
        qy = int'(r.query_y);
        qs = int'(r.query_size);
        case (r.action)
            stsp_pkg::ACT_WRITE:
            begin
                if (int'(r.slot_index) < N_SLOTS)
                begin
                    tbl_x[r.slot_index]    = r.entry_x;
                    tbl_y[r.slot_index]    = r.entry_y;
                    tbl_size[r.slot_index] = r.entry_size;
                    tbl_used[r.slot_index] = r.entry_used;
                    tbl_id[r.slot_index]   = r.entry_object_id;
                    tbl_key[r.slot_index]  = r.entry_key;
                end
            end
            stsp_pkg::ACT_COORD, stsp_pkg::ACT_ID, stsp_pkg::ACT_KEY, stsp_pkg::ACT_POINT:
            begin
                for (int i = 0; i < N_SLOTS && !a.found; i++)
                begin
                    if (tbl_used[i])
                    begin
                        h  = int'(tbl_size[i] >> 1);
                        sx = int'(tbl_x[i]);
                        sy = int'(tbl_y[i]);
                        if (r.action == stsp_pkg::ACT_COORD)
                            hit = (sx == qx) && (sy == qy);
                        else if (r.action == stsp_pkg::ACT_ID)
                            hit = tbl_id[i] == r.query_word;
                        else if (r.action == stsp_pkg::ACT_KEY)
                            hit = tbl_key[i] == r.query_word;
                        else
                            hit = qx >= sx - h && qx <= sx + h && qy >= sy - h && qy <= sy + h;
                        if (hit)
                        begin
                            a.found = 1'b1;
                            a.found_index = i[5:0];
                        end
                    end
                end
            end
            stsp_pkg::ACT_PLACE:
            begin
                any_free = 1'b0;
                blocked = 1'b0;
                for (int i = 0; i < N_SLOTS; i++)
                begin
                    if (!tbl_used[i])
                        any_free = 1'b1;
                    else if (int'(tbl_x[i]) == qx && int'(tbl_y[i]) == qy)
                        blocked = 1'b1;
                end
                if (any_free && !blocked)
                begin
                    a.placement_ok = 1'b1;
                    if (qs != 0)
                    begin
                        half = qs / 2;
                        x0 = qx - half;
                        x1 = qx + qs - half - 1;
                        y0 = qy - half;
                        y1 = qy + qs - half - 1;
                        for (int i = 0; i < N_SLOTS; i++)
                        begin
                            h  = int'(tbl_size[i] >> 1);
                            sx = int'(tbl_x[i]);
                            sy = int'(tbl_y[i]);
                            if (tbl_used[i] && x0 <= sx + h && x1 >= sx - h
                                && y0 <= sy + h && y1 >= sy - h)
                                a.placement_ok = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.action          = 3'($urandom_range(0, 7));
        r.slot_index      = 6'($urandom_range(0, 63));
        r.entry_x         = 8'($urandom_range(0, 255));
        r.entry_y         = 8'($urandom_range(0, 255));
        r.entry_size      = 8'($urandom_range(0, 255));
        r.entry_used      = 1'($urandom_range(0, 1));
        r.entry_object_id = $urandom();
        r.entry_key       = $urandom();
        r.query_x         = 11'($urandom_range(0, 2047));
        r.query_y         = 11'($urandom_range(0, 2047));
        r.query_size      = 8'($urandom_range(0, 255));
        r.query_word      = $urandom();
        return r;
    endfunction

    function automatic request_t write_request(int idx, bit used);
        request_t r;
        r = rand_request();
        r.action = stsp_pkg::ACT_WRITE;
        r.slot_index = 6'(idx);
        r.entry_used = used;
        if ($urandom_range(0, 3) != 0)
        begin
            r.entry_x = 8'($urandom_range(0, 40));
            r.entry_y = 8'($urandom_range(0, 40));
        end
        if ($urandom_range(0, 4) != 0)
            r.entry_size = 8'($urandom_range(0, 12));
        if ($urandom_range(0, 1) != 0)
            r.entry_object_id = $urandom_range(0, 7);
        if ($urandom_range(0, 1) != 0)
            r.entry_key = $urandom_range(0, 7);
        return r;
    endfunction

    function automatic request_t query_request(logic [2:0] act);
        request_t r;
        int       j;
        int       h;
        r = rand_request();
        r.action = act;
        j = int'($urandom_range(0, N_SLOTS - 1));
        h = int'(plan_size[j] >> 1);
        case (act)
            stsp_pkg::ACT_COORD:
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    r.query_x = 11'(plan_x[j]);
                    r.query_y = 11'(plan_y[j]);
                end
                else if ($urandom_range(0, 1) != 0)
                begin
                    r.query_x = 11'($urandom_range(0, 40));
                    r.query_y = 11'($urandom_range(0, 40));
                end
            end
            stsp_pkg::ACT_ID:
            begin
                if ($urandom_range(0, 2) != 0)
                    r.query_word = plan_id[j];
            end
            stsp_pkg::ACT_KEY:
            begin
                if ($urandom_range(0, 2) != 0)
                    r.query_word = plan_key[j];
            end
            stsp_pkg::ACT_POINT:
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r.query_x = 11'(int'(plan_x[j]) + int'($urandom_range(0, 2 * h + 2))
                                    - h - 1);
                    r.query_y = 11'(int'(plan_y[j]) + int'($urandom_range(0, 2 * h + 2))
                                    - h - 1);
                end
            end
            stsp_pkg::ACT_PLACE:
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r.query_x = 11'(int'(plan_x[j]) + int'($urandom_range(0, 40)) - 20);
                    r.query_y = 11'(int'(plan_y[j]) + int'($urandom_range(0, 40)) - 20);
                end
                case ($urandom_range(0, 3))
                    0:       r.query_size = 8'd0;
                    1, 2:    r.query_size = 8'($urandom_range(1, 16));
                    default: r.query_size = 8'($urandom_range(0, 255));
                endcase
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic request_t probe(logic [2:0] act, int qx, int qy, int qs,
                                       logic [31:0] word);
        request_t r;
        r = rand_request();
        r.action = act;
        r.query_x = 11'(qx);
        r.query_y = 11'(qy);
        r.query_size = 8'(qs);
        r.query_word = word;
        return r;
    endfunction

    task automatic push_request(input request_t r);
        if (r.action == stsp_pkg::ACT_WRITE)
        begin
            plan_x[r.slot_index]    = r.entry_x;
            plan_y[r.slot_index]    = r.entry_y;
            plan_size[r.slot_index] = r.entry_size;
            plan_used[r.slot_index] = r.entry_used;
            plan_id[r.slot_index]   = r.entry_object_id;
            plan_key[r.slot_index]  = r.entry_key;
        end
        if (r.action <= stsp_pkg::ACT_PLACE)
            n_items++;
        request_q.push_back(r);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || s_tvalid || answer_q.size() != 0)
            @(posedge clk);
    endtask

    // driver: bursts of requests with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !req_taken)
        begin
            // hold the request until it is taken
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            s_tvalid <= 1'b0;
        end
        else if (request_q.size() != 0)
        begin
            cur_req = request_q.pop_front();
            s_tdata <= {3'b000, cur_req.query_word, cur_req.query_size, cur_req.query_y,
                        cur_req.query_x, cur_req.entry_key, cur_req.entry_object_id,
                        cur_req.entry_used, cur_req.entry_size, cur_req.entry_y,
                        cur_req.entry_x, cur_req.slot_index};
            s_tuser <= cur_req.action;
            s_tvalid <= 1'b1;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 24);
                case ($urandom_range(0, 5))
                    0, 1:    gap_left = 0;
                    2, 3, 4: gap_left = $urandom_range(1, 6);
                    default: gap_left = $urandom_range(20, 90);
                endcase
            end
        end
        else
            s_tvalid <= 1'b0;
    end

    // receiver: runs of ready broken by short or long stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (ready_left > 0)
        begin
            ready_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            ready_left = $urandom_range(1, 60);
            case ($urandom_range(0, 3))
                0:       stall_left = 0;
                1, 2:    stall_left = $urandom_range(1, 4);
                default: stall_left = $urandom_range(20, 100);
            endcase
            m_tready <= (stall_left == 0);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        req_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                answer_q.push_back(slot_table_answer(cur_req));
            if (m_tvalid && m_tready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result with no request pending: tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_answer = answer_q.pop_front();
                    if (m_tdata[0] !== exp_answer.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_answer.found, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[6:1] !== exp_answer.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               exp_answer.found_index, m_tdata[6:1]);
                        fail_count++;
                    end
                    if (m_tdata[7] !== exp_answer.placement_ok)
                    begin
                        $error("placement_ok: expected %0d, got %0d",
                               exp_answer.placement_ok, m_tdata[7]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        request_t r;
        int       sel;
        bit       mid_pause;
        mid_pause = 1'b0;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            tbl_x[i] = '0;
            tbl_y[i] = '0;
            tbl_size[i] = '0;
            tbl_used[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_key[i] = '0;
            plan_x[i] = '0;
            plan_y[i] = '0;
            plan_size[i] = '0;
            plan_used[i] = 1'b0;
            plan_id[i] = '0;
            plan_key[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, spare codes, extreme slots and queries
        push_request(probe(stsp_pkg::ACT_PLACE, 0, 0, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_COORD, 0, 0, 0, 32'h0));
        push_request(probe(ACT_SPARE_LO, 0, 0, 0, 32'h0));
        push_request(probe(ACT_SPARE_HI, 1023, -1024, 255, 32'hFFFF_FFFF));
        r = write_request(0, 1'b1);
        r.entry_x = 8'd0;
        r.entry_y = 8'd0;
        r.entry_size = 8'd0;
        r.entry_object_id = 32'h0;
        r.entry_key = 32'h0;
        push_request(r);
        r = write_request(63, 1'b1);
        r.entry_x = 8'd255;
        r.entry_y = 8'd255;
        r.entry_size = 8'd255;
        r.entry_object_id = 32'hFFFF_FFFF;
        r.entry_key = 32'h8000_0000;
        push_request(r);
        r = write_request(5, 1'b0);
        r.entry_x = 8'd10;
        r.entry_y = 8'd20;
        r.entry_size = 8'd4;
        r.entry_object_id = 32'h7FFF_FFFF;
        r.entry_key = 32'h7FFF_FFFF;
        push_request(r);
        push_request(probe(stsp_pkg::ACT_COORD, 0, 0, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_COORD, 255, 255, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_COORD, -1024, -1024, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_COORD, 10, 20, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_ID, 0, 0, 0, 32'hFFFF_FFFF));
        push_request(probe(stsp_pkg::ACT_ID, 0, 0, 0, 32'h7FFF_FFFF));
        push_request(probe(stsp_pkg::ACT_KEY, 0, 0, 0, 32'h8000_0000));
        push_request(probe(stsp_pkg::ACT_KEY, 0, 0, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_POINT, 128, 128, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_POINT, 127, 127, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_POINT, 1023, 1023, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_PLACE, 0, 0, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_PLACE, 5, 5, 0, 32'h0));
        push_request(probe(stsp_pkg::ACT_PLACE, 100, 100, 255, 32'h0));
        push_request(probe(stsp_pkg::ACT_PLACE, -1024, -1024, 255, 32'h0));
        push_request(probe(stsp_pkg::ACT_PLACE, 1023, 1023, 1, 32'h0));
        push_request(write_request(0, 1'b0));
        wait_drained();

        // random: short write/query sequences, full-table runs, noise
        while (n_items < ITEM_TARGET)
        begin
            sel = int'($urandom_range(0, 99));
            if (sel < 1)
            begin
                for (int s = 0; s < N_SLOTS; s++)
                    push_request(write_request(s, 1'b1));
                repeat ($urandom_range(3, 8))
                    push_request(query_request(3'($urandom_range(1, 5))));
                repeat ($urandom_range(1, 6))
                    push_request(write_request(int'($urandom_range(0, N_SLOTS - 1)), 1'b0));
            end
            else if (sel < 8)
                push_request(rand_request());
            else
            begin
                repeat ($urandom_range(0, 3))
                    push_request(write_request(int'($urandom_range(0, N_SLOTS - 1)),
                                               $urandom_range(0, 3) != 0));
                repeat ($urandom_range(1, 4))
                    push_request(query_request(3'($urandom_range(1, 5))));
            end
            if (!mid_pause && n_items >= ITEM_TARGET / 2)
            begin
                mid_pause = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (N_SLOTS + 16) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
